// ----- design/multi_policy_job_scheduler_core_assert.svh -----
// Assertion macros for the scheduler core.
`ifndef MULTI_POLICY_JOB_SCHEDULER_CORE_ASSERT_SVH
`define MULTI_POLICY_JOB_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define MPJS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MPJS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MPJS_ASSERT(label, clk, rst_n, prop, msg)
`define MPJS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ----- design/mpjs_pkg.sv -----
package mpjs_pkg;
  localparam int unsigned MaxJobsDef = 16;
  localparam int unsigned EntryW = 8 + 32 + 16 + 16 + 8 + 32 + 1;

  localparam logic [2:0] ModeFcfs = 3'd0;
  localparam logic [2:0] ModeNeed = 3'd1;
  localparam logic [2:0] ModeRem  = 3'd2;
  localparam logic [2:0] ModePrio = 3'd3;
  localparam logic [2:0] ModeRr   = 3'd4;

  localparam logic RegMode  = 1'b0;
  localparam logic RegSlice = 1'b1;

  localparam logic CmdAdd  = 1'b0;
  localparam logic CmdTick = 1'b1;

  localparam logic [2:0] StAdded = 3'd0;
  localparam logic [2:0] StFull  = 3'd1;
  localparam logic [2:0] StIdle  = 3'd2;
  localparam logic [2:0] StRan   = 3'd3;
  localparam logic [2:0] StDone  = 3'd4;

  typedef struct packed {
    logic [7:0]  tag;
    logic [31:0] arrival;
    logic [15:0] need;
    logic [15:0] remain;
    logic [7:0]  prio;
    logic [31:0] start;
    logic        started;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_RUN, S_SHIFT, S_PUT, S_OUT
  } state_e;
endpackage

// ----- design/multi_policy_job_scheduler_core.sv -----
// Tick-driven job scheduler with five policies: first come first served,
// shortest total need, shortest remaining time, lowest priority value, and
// round robin with a programmable slice. Job records live in one synchronous
// RAM in queue order. An input beat carries its command on s_axis_tuser
// (0 adds a job, 1 advances one tick) and the job fields on s_axis_tdata.
// Each result beat carries its status on m_axis_tuser. One beat is in work at
// a time. A tick on N queued jobs reads every entry once to find the pick.
// When the job finishes or is requeued, the entries behind it move up one
// place, one entry per cycle through the single RAM port. A finished result
// waits in the output register, so the next input beat is taken while the
// sink stalls. The result of that beat then waits in the core until the
// register frees. Write the configuration registers only while no beat is in
// work.
module multi_policy_job_scheduler_core
  import mpjs_pkg::*;
#(
  parameter int unsigned MaxJobs = MaxJobsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [7:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // From bit 0: command.
  input  logic         s_axis_tuser,
  // From bit 0: job_tag, need_time, priority_level.
  input  logic [31:0]  s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // From bit 0: status.
  output logic [2:0]   m_axis_tuser,
  // From bit 0: run_tag, tick_time, first_run_time, turnaround, waiting,
  // response.
  output logic [167:0] m_axis_tdata
);
`include "multi_policy_job_scheduler_core_assert.svh"

  localparam int unsigned IdxW = $clog2(MaxJobs);
  localparam int unsigned CntW = $clog2(MaxJobs + 1);

  state_e state_q, state_d;
  logic [2:0] mode_q;
  logic [7:0] slice_q;
  logic [CntW-1:0] len_q, len_d, ads_q, ads_d;
  logic [31:0] time_q, time_d;
  logic [7:0] used_q, used_d;
  logic [CntW-1:0] cnt_q, cnt_d;        // scan / shift index
  logic [IdxW-1:0] best_q, best_d;
  entry_t best_e_q, best_e_d, hold_q, hold_d;
  logic [CntW-1:0] dst_q, dst_d;        // requeue destination
  logic cmd_q;
  logic [7:0] tag_q;
  logic [15:0] need_q;
  logic [7:0] prio_q;
  logic [170:0] res_q, res_d;
  logic [170:0] out_q;
  logic out_v_q, out_v_d;
  logic pend_q, pend_d;                 // result computed, waiting for out reg

  logic we;
  logic [IdxW-1:0] waddr, raddr;
  entry_t wdata, rdata;
  logic scan_v_q, scan_v_d;             // rdata valid for entry cnt_q-1

  mpjs_ram #(.Width(EntryW), .Depth(MaxJobs)) u_ram (
    .clk_i, .we_i(we), .waddr_i(waddr), .wdata_i(wdata),
    .raddr_i(raddr), .rdata_o(rdata)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tuser  = out_q[2:0];
  assign m_axis_tdata  = out_q[170:3];

  function automatic logic better(input logic [2:0] m, input entry_t c, input entry_t b);
    logic r;
    r = 1'b0;
    case (m)
      ModeNeed: r = c.need < b.need;
      ModeRem:  r = c.remain < b.remain;
      ModePrio: r = c.prio < b.prio;
      default:  r = 1'b0;
    endcase
    return r;
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      mode_q <= ModeFcfs;
      slice_q <= 8'd4;
      len_q <= '0;
      ads_q <= '0;
      time_q <= '0;
      used_q <= '0;
      out_v_q <= 1'b0;
      pend_q <= 1'b0;
      scan_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      len_q <= len_d;
      ads_q <= ads_d;
      time_q <= time_d;
      used_q <= used_d;
      out_v_q <= out_v_d;
      pend_q <= pend_d;
      scan_v_q <= scan_v_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegMode:  mode_q <= cfg_data_i[2:0];
          RegSlice: slice_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    best_q <= best_d;
    best_e_q <= best_e_d;
    hold_q <= hold_d;
    dst_q <= dst_d;
    res_q <= res_d;
    // The output register only loads once the previous beat has left.
    if (state_q == S_OUT && (!out_v_q || m_axis_tready)) begin
      out_q <= res_q;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= s_axis_tuser;
      tag_q <= s_axis_tdata[7:0];
      need_q <= s_axis_tdata[23:8];
      prio_q <= s_axis_tdata[31:24];
    end
  end

  logic [7:0] eff_slice;
  always_comb begin
    eff_slice = (slice_q == 8'd0) ? 8'd1 : slice_q;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (s_axis_tvalid) state_d = S_SCAN;
      S_SCAN: begin
        if (cmd_q == CmdAdd || len_q == '0) state_d = S_OUT;
        else if (scan_v_q && cnt_q == len_q) state_d = S_RUN;
      end
      S_RUN:   state_d = S_SHIFT;
      S_SHIFT: if (cnt_q >= dst_q) state_d = S_PUT;
      S_PUT:   state_d = S_OUT;
      S_OUT:   if (!out_v_q || m_axis_tready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    len_d = len_q; ads_d = ads_q; time_d = time_q; used_d = used_q;
    cnt_d = cnt_q; best_d = best_q; best_e_d = best_e_q; hold_d = hold_q;
    dst_d = dst_q; res_d = res_q; pend_d = pend_q; scan_v_d = 1'b0;
    out_v_d = out_v_q && !m_axis_tready;
    we = 1'b0; waddr = '0; wdata = '0; raddr = '0;
    case (state_q)
      S_IDLE: begin
        cnt_d = '0;
        best_d = '0;
      end
      S_SCAN: begin
        if (cmd_q == CmdAdd) begin
          res_d = '0;
          res_d[10:3] = tag_q;
          res_d[42:11] = time_q;
          if (len_q >= CntW'(MaxJobs)) begin
            res_d[2:0] = StFull;
          end else begin
            res_d[2:0] = StAdded;
            we = 1'b1;
            waddr = len_q[IdxW-1:0];
            wdata = '{tag: tag_q, arrival: time_q, need: need_q, remain: need_q,
                      prio: prio_q, start: 32'd0, started: 1'b0};
            len_d = len_q + 1'b1;
            if (mode_q == ModeRr && used_q != '0 && ads_q < CntW'(MaxJobs))
              ads_d = ads_q + 1'b1;
          end
          pend_d = 1'b1;
        end else if (len_q == '0) begin
          res_d = '0;
          res_d[2:0] = StIdle;
          res_d[42:11] = time_q;
          time_d = time_q + 32'd1;
          used_d = '0; ads_d = '0;
          pend_d = 1'b1;
        end else begin
          if (cnt_q < len_q) begin
            raddr = cnt_q[IdxW-1:0];
            cnt_d = cnt_q + 1'b1;
            scan_v_d = 1'b1;
          end
          if (scan_v_q) begin
            if (cnt_q == CntW'(1) ||
                (mode_q != ModeRr && better(mode_q, rdata, best_e_q))) begin
              best_d = IdxW'(cnt_q - 1'b1);
              best_e_d = rdata;
            end
          end
        end
      end
      S_RUN: begin
        // Update the picked entry and form the result.
        hold_d = best_e_q;
        if (!best_e_q.started) begin
          hold_d.start = time_q;
          hold_d.started = 1'b1;
        end
        res_d = '0;
        res_d[10:3] = best_e_q.tag;
        res_d[42:11] = time_q;
        res_d[74:43] = hold_d.start;
        time_d = time_q + 32'd1;
        cnt_d = CntW'(best_q) + 1'b1;
        if (best_e_q.remain <= 16'd1) begin
          res_d[2:0] = StDone;
          res_d[106:75] = time_q + 32'd1 - best_e_q.arrival;
          res_d[138:107] = time_q + 32'd1 - best_e_q.arrival - {16'd0, best_e_q.need};
          res_d[170:139] = hold_d.start - best_e_q.arrival;
          used_d = '0; ads_d = '0;
          dst_d = len_q;            // shift all behind up, no put
          len_d = len_q - 1'b1;
        end else begin
          res_d[2:0] = StRan;
          hold_d.remain = best_e_q.remain - 1'b1;
          dst_d = CntW'(best_q);    // rewrite in place
          if (mode_q == ModeRr) begin
            if (used_q + 8'd1 >= eff_slice) begin
              used_d = '0; ads_d = '0;
              if (len_q >= CntW'(2)) begin
                dst_d = len_q - 1'b1 - ((ads_q > len_q - 1'b1) ? len_q - 1'b1 : ads_q);
              end
            end else begin
              used_d = used_q + 8'd1;
            end
          end else begin
            used_d = '0; ads_d = '0;
          end
        end
        raddr = IdxW'(cnt_d);
        pend_d = 1'b1;
      end
      S_SHIFT: begin
        // rdata holds entry cnt_q; move it to cnt_q-1.
        if (cnt_q <= dst_q && cnt_q <= len_q) begin
          we = 1'b1;
          waddr = IdxW'(cnt_q - 1'b1);
          wdata = rdata;
          cnt_d = cnt_q + 1'b1;
          raddr = IdxW'(cnt_d);
        end else begin
          cnt_d = dst_q;
        end
      end
      S_PUT: begin
        if (res_q[2:0] == StRan) begin
          we = 1'b1;
          waddr = IdxW'(dst_q);
          wdata = hold_q;
        end
      end
      S_OUT: begin
        if (!out_v_q || m_axis_tready) begin
          out_v_d = 1'b1;
          pend_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  `MPJS_ASSERT(a_len_max, clk_i, rst_ni, len_q <= CntW'(MaxJobs), "queue overflow")
  `MPJS_ASSERT(a_out_hold, clk_i, rst_ni, out_v_q && !m_axis_tready |=> out_v_q,
    "result dropped")
  `MPJS_ASSERT(a_out_stable, clk_i, rst_ni, out_v_q && !m_axis_tready |=> $stable(out_q),
    "result changed while waiting")
  `MPJS_ASSERT(a_ready_idle, clk_i, rst_ni, s_axis_tready |-> !pend_q,
    "input taken with result pending")
endmodule

// ----- design/mpjs_ram.sv -----
module mpjs_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ----- verif/multi_policy_job_scheduler_checker.sv -----
module multi_policy_job_scheduler_checker
  import mpjs_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_index_i,
  input  logic [7:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic         s_axis_tuser,
  input  logic [31:0]  s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [2:0]   m_axis_tuser,
  input  logic [167:0] m_axis_tdata,
  output int           fail_count_o,
  output int           pending_o,
  output int           done_count_o,
  output int           full_count_o,
  output int           idle_count_o
);

  localparam int unsigned TableDepth = MaxJobsDef;

  typedef struct packed {
    logic [31:0] response;
    logic [31:0] waiting;
    logic [31:0] turnaround;
    logic [31:0] first_run;
    logic [31:0] tick_time;
    logic [7:0]  run_tag;
    logic [2:0]  status;
  } sched_result_t;

  entry_t        job_table [TableDepth];
  int unsigned   queued_jobs;
  logic [31:0]   sched_now;
  int unsigned   slice_ticks;
  int unsigned   late_arrivals;
  logic [2:0]    policy;
  logic [7:0]    slice_len;
  sched_result_t expected_results [$];

  // Pick the job to run: the first entry holding the least key for the
  // comparing policies, the head for everything else.
  function automatic int unsigned pick_job();
    int unsigned best;
    best = 0;
    for (int unsigned i = 1; i < queued_jobs; i++) begin
      if ((policy == ModeNeed && job_table[i].need < job_table[best].need) ||
          (policy == ModeRem && job_table[i].remain < job_table[best].remain) ||
          (policy == ModePrio && job_table[i].prio < job_table[best].prio)) begin
        best = i;
      end
    end
    return best;
  endfunction

  task automatic predict_schedule(input logic cmd, input logic [7:0] tag,
                                  input logic [15:0] need, input logic [7:0] prio,
                                  output sched_result_t res);
    int unsigned   k;
    int unsigned   ahead;
    int unsigned   slot;
    entry_t        head;
    logic [31:0]   ta;
    res = '0;
    res.tick_time = sched_now;
    if (cmd == CmdAdd) begin
      res.run_tag = tag;
      if (queued_jobs >= TableDepth) begin
        res.status = StFull;
      end else begin
        job_table[queued_jobs] = '{tag: tag, arrival: sched_now, need: need, remain: need,
                                   prio: prio, start: '0, started: 1'b0};
        queued_jobs++;
        if (policy == ModeRr && slice_ticks > 0 && late_arrivals < TableDepth) begin
          late_arrivals++;
        end
        res.status = StAdded;
      end
    end else begin
      sched_now = sched_now + 32'd1;
      if (queued_jobs == 0) begin
        res.status    = StIdle;
        slice_ticks   = 0;
        late_arrivals = 0;
      end else begin
        k = (policy == ModeRr) ? 0 : pick_job();
        if (!job_table[k].started) begin
          job_table[k].start   = res.tick_time;
          job_table[k].started = 1'b1;
        end
        res.run_tag   = job_table[k].tag;
        res.first_run = job_table[k].start;
        if (job_table[k].remain <= 16'd1) begin
          ta             = res.tick_time + 32'd1 - job_table[k].arrival;
          res.status     = StDone;
          res.turnaround = ta;
          res.waiting    = ta - {16'd0, job_table[k].need};
          res.response   = job_table[k].start - job_table[k].arrival;
          for (int unsigned i = k; i + 1 < queued_jobs; i++) begin
            job_table[i] = job_table[i + 1];
          end
          queued_jobs--;
          slice_ticks   = 0;
          late_arrivals = 0;
        end else begin
          job_table[k].remain = job_table[k].remain - 16'd1;
          res.status = StRan;
          if (policy == ModeRr) begin
            slice_ticks++;
            if (slice_ticks >= slice_len) begin
              // The preempted head goes behind every older job but stays ahead of the
              // jobs that came during its slice.
              if (queued_jobs >= 2) begin
                ahead = (late_arrivals > queued_jobs - 1) ? queued_jobs - 1 : late_arrivals;
                slot  = queued_jobs - 1 - ahead;
                head  = job_table[0];
                for (int unsigned i = 0; i < slot; i++) begin
                  job_table[i] = job_table[i + 1];
                end
                job_table[slot] = head;
              end
              slice_ticks   = 0;
              late_arrivals = 0;
            end
          end else begin
            slice_ticks   = 0;
            late_arrivals = 0;
          end
        end
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sched_result_t res;
    sched_result_t got;
    if (!rst_ni) begin
      queued_jobs   = 0;
      sched_now     = '0;
      slice_ticks   = 0;
      late_arrivals = 0;
      policy        = ModeFcfs;
      slice_len     = 8'd4;
      fail_count_o  = 0;
      done_count_o  = 0;
      full_count_o  = 0;
      idle_count_o  = 0;
      expected_results.delete();
      pending_o     = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == RegMode) begin
          policy = cfg_data_i[2:0];
        end else begin
          slice_len = cfg_data_i;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        predict_schedule(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[23:8],
                         s_axis_tdata[31:24], res);
        expected_results.insert(expected_results.size(), res);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = {m_axis_tdata, m_axis_tuser};
        if (expected_results.size() == 0) begin
          $error("result beat with no expectation pending: %h", got);
          fail_count_o++;
        end else begin
          res = expected_results.pop_front();
          case (got.status)
            StDone: done_count_o++;
            StFull: full_count_o++;
            StIdle: idle_count_o++;
            default: ;
          endcase
          if (got.status !== res.status) begin
            $error("status: expected %0d, got %0d", res.status, got.status);
            fail_count_o++;
          end
          if (got.run_tag !== res.run_tag) begin
            $error("run_tag: expected %0d, got %0d", res.run_tag, got.run_tag);
            fail_count_o++;
          end
          if (got.tick_time !== res.tick_time) begin
            $error("tick_time: expected %0d, got %0d", res.tick_time, got.tick_time);
            fail_count_o++;
          end
          if (got.first_run !== res.first_run) begin
            $error("first_run_time: expected %0d, got %0d", res.first_run, got.first_run);
            fail_count_o++;
          end
          if (got.turnaround !== res.turnaround) begin
            $error("turnaround: expected %0d, got %0d", res.turnaround, got.turnaround);
            fail_count_o++;
          end
          if (got.waiting !== res.waiting) begin
            $error("waiting: expected %0d, got %0d", res.waiting, got.waiting);
            fail_count_o++;
          end
          if (got.response !== res.response) begin
            $error("response: expected %0d, got %0d", res.response, got.response);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_results.size();
    end
  end

endmodule

// ----- verif/tb_multi_policy_job_scheduler_core.sv -----
module tb_multi_policy_job_scheduler_core;
  import mpjs_pkg::*;

  // Mode values above round robin are expected to fall back to first come,
  // first served.
  localparam logic [2:0] ModeSpareLo = 3'd5;
  localparam logic [2:0] ModeSpareHi = 3'd7;
  localparam int         CycleLimit  = 400000;

  logic         clk_i;
  logic         rst_ni;
  logic         cfg_we_i;
  logic         cfg_index_i;
  logic [7:0]   cfg_data_i;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // From bit 0: command.
  logic         s_axis_tuser;
  // From bit 0: job_tag, need_time, priority_level.
  logic [31:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // From bit 0: status.
  logic [2:0]   m_axis_tuser;
  // From bit 0: run_tag, tick_time, first_run_time, turnaround, waiting,
  // response.
  logic [167:0] m_axis_tdata;

  int fail_count;
  int pending;
  int done_count;
  int full_count;
  int idle_count;
  int cycle_count;
  int burst_left;
  int sent_count;

  multi_policy_job_scheduler_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata)
  );

  multi_policy_job_scheduler_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .done_count_o  (done_count),
    .full_count_o  (full_count),
    .idle_count_o  (idle_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The cycle counter doubles as the watchdog. The limit is many times the
  // slowest legal run: every tick shifting a full table, every result held
  // by the sink, plus the long hold-off and the sender's gaps.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // The sink changes its temperament in turn: always ready, mostly ready, or
  // mostly stalled. Once early in the run, and now and then at random, it
  // holds off long enough that the scheduler fills its output register and
  // stops taking input beats.
  int hold_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 0;
    end else if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (cycle_count == 1500 || $urandom_range(0, 4999) == 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= 300;
    end else begin
      case ((cycle_count / 64) % 3)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  // Offers one beat and returns at the edge where it is taken. The valid
  // stays high so that the next beat of a burst follows back to back; at the
  // end of a burst the source goes quiet for a random gap.
  task automatic send_job(input logic cmd, input logic [7:0] tag,
                          input logic [15:0] need, input logic [7:0] prio);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {prio, need, tag};
    do @(posedge clk_i); while (!s_axis_tready);
    sent_count++;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 60))
                                                : int'($urandom_range(0, 10));
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  // Registers only change with the scheduler quiet and every result home.
  task automatic write_reg(input logic idx, input logic [7:0] value);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic tick();
    send_job(CmdTick, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 65535)),
             8'($urandom_range(0, 255)));
  endtask

  // Random traffic: mostly adds of short jobs mixed with ticks, so the table
  // both drains and fills up; a few jobs carry very long needs when allowed.
  task automatic random_phase(input int count, input int add_pct, input bit long_jobs);
    logic [15:0] need;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < add_pct) begin
        if (long_jobs && $urandom_range(0, 9) == 0) begin
          need = 16'($urandom_range(0, 65535));
        end else if ($urandom_range(0, 19) == 0) begin
          need = 16'd0;
        end else begin
          need = 16'($urandom_range(1, 6));
        end
        send_job(CmdAdd, 8'($urandom_range(0, 255)), need, 8'($urandom_range(0, 255)));
      end else begin
        tick();
      end
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_index_i   = RegMode;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser  = CmdAdd;
    s_axis_tdata  = '0;
    cycle_count   = 0;
    burst_left    = 0;
    sent_count    = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, at reset settings (first come, first served, slice 4):
    // an idle tick on the empty table, the tag and priority extremes and a
    // zero-need job that finishes on its first tick.
    tick();
    send_job(CmdAdd, 8'h00, 16'd1, 8'h00);
    send_job(CmdAdd, 8'hFF, 16'd0, 8'hFF);
    send_job(CmdAdd, 8'h5A, 16'd3, 8'h80);
    repeat (6) tick();

    // Out-of-range mode and a zero slice.
    write_reg(RegMode, ModeSpareHi);
    write_reg(RegSlice, 8'd0);
    send_job(CmdAdd, 8'hC3, 16'd2, 8'h01);
    send_job(CmdAdd, 8'h3C, 16'd1, 8'h00);
    repeat (3) tick();

    // Round robin with a one-tick slice, with an arrival between ticks.
    write_reg(RegMode, ModeRr);
    write_reg(RegSlice, 8'd1);
    send_job(CmdAdd, 8'h11, 16'd2, 8'h10);
    send_job(CmdAdd, 8'h22, 16'd2, 8'h20);
    repeat (2) tick();
    send_job(CmdAdd, 8'h33, 16'd1, 8'h30);
    repeat (4) tick();

    // Random part, walking through every policy and the slice extremes.
    write_reg(RegMode, ModeFcfs);
    random_phase(95, 50, 1'b0);
    write_reg(RegMode, ModeNeed);
    random_phase(95, 55, 1'b0);
    write_reg(RegMode, ModeRem);
    write_reg(RegSlice, 8'd9);
    random_phase(95, 55, 1'b0);
    write_reg(RegMode, ModePrio);
    random_phase(95, 65, 1'b0);
    write_reg(RegMode, ModeRr);
    write_reg(RegSlice, 8'd1);
    random_phase(95, 50, 1'b0);
    write_reg(RegSlice, 8'd255);
    random_phase(95, 50, 1'b0);
    write_reg(RegSlice, 8'd0);
    random_phase(80, 50, 1'b0);
    write_reg(RegSlice, 8'd3);
    random_phase(95, 65, 1'b0);
    write_reg(RegMode, ModeSpareLo);
    random_phase(80, 50, 1'b0);

    // Last comes shortest remaining time with some very long jobs; those are
    // never expected to finish, which is why they wait until the end.
    write_reg(RegMode, ModeRem);
    write_reg(RegSlice, 8'd4);
    send_job(CmdAdd, 8'hA5, 16'hFFFF, 8'hFF);
    random_phase(95, 60, 1'b1);

    wait_drained();
    repeat (60) @(posedge clk_i);
    $display("Sent %0d beats over five policies, spare modes and slices 0, 1, 3, 4, 9, 255.",
             sent_count);
    $display("Results seen: %0d jobs finished, %0d refused on a full table, %0d idle ticks.",
             done_count, full_count, idle_count);
    if (fail_count == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
